/* rtl/hts_pkg.sv */
// Shared types, constants and register codes for the heater thermostat.
package hts_pkg;

    localparam int TOP_MODE_DEF      = 5;
    localparam int MODE_W            = 3;
    localparam int TEMP_W            = 10;
    localparam int CMP_W             = TEMP_W + 1;
    localparam int SP_W              = 8;
    localparam int NUM_SETPOINTS     = 6;
    localparam int TABLE_W           = SP_W * NUM_SETPOINTS;
    localparam int SEC_W             = 14;
    localparam int SECONDS_PER_MIN   = 60;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = TABLE_W;

    localparam logic [MODE_W-1:0] MODE_RESET = 3'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SETPOINT_TABLE = 3'd0,
        CFG_UPPER_MARGIN   = 3'd1,
        CFG_LOWER_MARGIN   = 3'd2,
        CFG_MIN_RUN        = 3'd3,
        CFG_MIN_IDLE       = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        ACT_BUTTON = 1'b0,
        ACT_TICK   = 1'b1
    } t_action;

    typedef struct packed {
        logic [TABLE_W-1:0] setpoint_table;
        logic [7:0]         upper_margin;
        logic [7:0]         lower_margin;
        logic [7:0]         min_run_minutes;
        logic [7:0]         min_idle_minutes;
    } t_cfg;

    typedef struct packed {
        logic [MODE_W-1:0] mode_level;
        logic              last_up_level;
        logic              last_down_level;
        logic              relay_state;
        logic [SEC_W-1:0]  seconds_in_state;
    } t_state;

    typedef struct packed {
        logic              relay_on;
        logic [MODE_W-1:0] heat_mode;
        logic              beep_start;
        logic              beep_is_down;
    } t_result;

endpackage

/* rtl/heater_thermostat_with_mode_buttons.sv */
// Top level of the heater thermostat: state, configuration and result register.
//
//  channel  direction  handshake              payload
//  in       input      i_in_valid/o_in_stall  action, up_level, down_level, temperature
//  out      output     o_out_valid/i_out_stall relay_on, heat_mode, beep_start, beep_is_down
//  cfg      input      i_cfg_we               i_cfg_index, i_cfg_data
//
//  One word per cycle unless stalled; the result register loads its result on accept.
//  The whole step is one pass of compare and counter logic from the ports to the registers.
//  A new word is taken while the result register is full, as long as it is being taken too.
//  A stalled result holds; the input stalls only while the result register stays full.
//  Reset (synchronous, active low) restores the register defaults and mode 3, relay off.
module heater_thermostat_with_mode_buttons
    import hts_pkg::*;
#(
    parameter int TOP_MODE = TOP_MODE_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_action,
    input  logic                     i_up_level,
    input  logic                     i_down_level,
    input  logic signed [TEMP_W-1:0] i_temperature,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic                     o_relay_on,
    output logic [MODE_W-1:0]        o_heat_mode,
    output logic                     o_beep_start,
    output logic                     o_beep_is_down,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data
);

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_result r_result;
    t_result n_result;
    logic    r_out_valid;
    logic    accept;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    hts_step #(
        .TOP_MODE (TOP_MODE)
    ) u_step (
        .i_cfg         (r_cfg),
        .i_state       (r_state),
        .i_action      (i_action),
        .i_up_level    (i_up_level),
        .i_down_level  (i_down_level),
        .i_temperature (i_temperature),
        .o_state       (n_state),
        .o_result      (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.setpoint_table   <= '0;
            r_cfg.upper_margin     <= 8'd2;
            r_cfg.lower_margin     <= 8'd2;
            r_cfg.min_run_minutes  <= 8'd5;
            r_cfg.min_idle_minutes <= 8'd5;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SETPOINT_TABLE: r_cfg.setpoint_table   <= i_cfg_data[TABLE_W-1:0];
                CFG_UPPER_MARGIN:   r_cfg.upper_margin     <= i_cfg_data[7:0];
                CFG_LOWER_MARGIN:   r_cfg.lower_margin     <= i_cfg_data[7:0];
                CFG_MIN_RUN:        r_cfg.min_run_minutes  <= i_cfg_data[7:0];
                CFG_MIN_IDLE:       r_cfg.min_idle_minutes <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode_level       <= MODE_RESET;
            r_state.last_up_level    <= 1'b1;
            r_state.last_down_level  <= 1'b1;
            r_state.relay_state      <= 1'b0;
            r_state.seconds_in_state <= '0;
            r_out_valid              <= 1'b0;
        end else begin
            if (accept) begin
                r_state <= n_state;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_relay_on     = r_result.relay_on;
    assign o_heat_mode    = r_result.heat_mode;
    assign o_beep_start   = r_result.beep_start;
    assign o_beep_is_down = r_result.beep_is_down;

    a_mode_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.mode_level <= MODE_W'(TOP_MODE))
        else $error("heat mode above top mode");

    a_mode0_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_action == ACT_TICK && r_state.mode_level == '0 |=> !r_state.relay_state)
        else $error("relay on in mode 0 after tick");

    a_change_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && n_state.relay_state != r_state.relay_state |=> r_state.seconds_in_state == '0)
        else $error("relay change did not clear counter");

    a_button_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_action == ACT_BUTTON
        |=> $stable(r_state.relay_state) && $stable(r_state.seconds_in_state))
        else $error("button word changed relay timing");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty result register");

endmodule

/* rtl/hts_step.sv */
// Next-state and result logic for one button sample or control tick.
module hts_step
    import hts_pkg::*;
#(
    parameter int TOP_MODE = TOP_MODE_DEF
) (
    input  t_cfg                     i_cfg,
    input  t_state                   i_state,
    input  logic                     i_action,
    input  logic                     i_up_level,
    input  logic                     i_down_level,
    input  logic signed [TEMP_W-1:0] i_temperature,
    output t_state                   o_state,
    output t_result                  o_result
);

    localparam logic [MODE_W-1:0] MODE_MAX = MODE_W'(TOP_MODE);

    logic                    down_edge;
    logic                    up_edge;
    logic [MODE_W-1:0]       mode_a;
    logic [MODE_W-1:0]       mode_b;
    logic [SEC_W-1:0]        run_lim;
    logic [SEC_W-1:0]        idle_lim;
    logic [SEC_W-1:0]        lim;
    logic [SEC_W-1:0]        sec_inc;
    logic [SEC_W-1:0]        sec_cap;
    logic [SP_W-1:0]         sp;
    logic signed [CMP_W-1:0] temp_x;
    logic signed [CMP_W-1:0] sp_hi;
    logic signed [CMP_W-1:0] sp_lo;
    logic                    relay_next;

    // mode buttons: down edge first, then up
    always_comb begin
        down_edge = !i_down_level && i_state.last_down_level;
        up_edge   = !i_up_level && i_state.last_up_level;
        mode_a    = (down_edge && i_state.mode_level != '0)
                    ? i_state.mode_level - MODE_W'(1) : i_state.mode_level;
        mode_b    = (up_edge && mode_a < MODE_MAX) ? mode_a + MODE_W'(1) : mode_a;
    end

    always_comb begin
        unique case (i_state.mode_level)
            3'd0:    sp = i_cfg.setpoint_table[0*SP_W +: SP_W];
            3'd1:    sp = i_cfg.setpoint_table[1*SP_W +: SP_W];
            3'd2:    sp = i_cfg.setpoint_table[2*SP_W +: SP_W];
            3'd3:    sp = i_cfg.setpoint_table[3*SP_W +: SP_W];
            3'd4:    sp = i_cfg.setpoint_table[4*SP_W +: SP_W];
            3'd5:    sp = i_cfg.setpoint_table[5*SP_W +: SP_W];
            default: sp = '0;
        endcase
    end

    // run/idle timing and hysteresis
    always_comb begin
        run_lim  = SEC_W'({6'd0, i_cfg.min_run_minutes} * SEC_W'(SECONDS_PER_MIN));
        idle_lim = SEC_W'({6'd0, i_cfg.min_idle_minutes} * SEC_W'(SECONDS_PER_MIN));
        lim      = i_state.relay_state ? run_lim : idle_lim;
        sec_inc  = i_state.seconds_in_state + SEC_W'(1);
        sec_cap  = (sec_inc > lim) ? lim + SEC_W'(1) : sec_inc;

        temp_x = CMP_W'(i_temperature);
        sp_hi  = $signed({3'd0, sp}) + $signed({3'd0, i_cfg.upper_margin});
        sp_lo  = $signed({3'd0, sp}) - $signed({3'd0, i_cfg.lower_margin});

        relay_next = i_state.relay_state;
        if (i_state.mode_level == '0) begin
            relay_next = 1'b0;
        end else if (temp_x > sp_hi && sec_cap > run_lim) begin
            relay_next = 1'b0;
        end else if (temp_x < sp_lo && sec_cap > idle_lim) begin
            relay_next = 1'b1;
        end
    end

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        if (i_action == ACT_BUTTON) begin
            o_state.mode_level      = mode_b;
            o_state.last_down_level = i_down_level;
            o_state.last_up_level   = i_up_level;
            o_result.beep_start     = down_edge || up_edge;
            o_result.beep_is_down   = down_edge && !up_edge;
        end else begin
            o_state.relay_state      = relay_next;
            o_state.seconds_in_state = (relay_next != i_state.relay_state) ? '0 : sec_cap;
        end
        o_result.relay_on  = o_state.relay_state;
        o_result.heat_mode = o_state.mode_level;
    end

endmodule
